[design/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising edge outside reset.
`define SRP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("srp assertion failed");

// Checks that a condition is followed in the next cycle by another.
`define SRP_ASSERT_NEXT(lbl, a, b) \
  `SRP_ASSERT(lbl, (a) |=> (b))

`endif

[design/srp_pkg.sv]
package srp_pkg;

  localparam int FRAC_BITS      = 16;
  localparam int COORD_BITS     = 32;
  localparam int FRAMES_PER_ROW = 4;

  localparam int MUL_W   = COORD_BITS + 2;
  localparam int PROD_W  = 2 * MUL_W;
  localparam int PD_W    = 2 * COORD_BITS + 2;
  localparam int S_W     = PD_W + 1;
  localparam int LO_W    = MUL_W - 1;
  localparam int DIV_NW  = PD_W + FRAC_BITS;
  localparam int DIV_DW  = PD_W + 1;
  localparam int DIV_CW  = $clog2(DIV_NW + 1);
  localparam int SMALL_N = 32;

  localparam int THRESH = ((1 << FRAC_BITS) + 5) / 10;
  localparam int SCALE  = ((1 << FRAC_BITS) * 55 + 50) / 100;

  localparam logic [2:0] REG_SCREEN_W  = 3'd0;
  localparam logic [2:0] REG_SCREEN_H  = 3'd1;
  localparam logic [2:0] REG_FRAME_W   = 3'd2;
  localparam logic [2:0] REG_FRAME_H   = 3'd3;
  localparam logic [2:0] REG_TWO_ROW   = 3'd4;

  typedef struct packed {
    logic              start;
    logic [DIV_CW-1:0] iters;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_rsp_t;

  function automatic logic [12:0] clamp_screen(input logic [12:0] v);
    if (v == 13'd0) begin
      return 13'd1;
    end else if (v > 13'd4096) begin
      return 13'd4096;
    end
    return v;
  endfunction

  function automatic logic [10:0] clamp_frame(input logic [10:0] v);
    if (v == 11'd0) begin
      return 11'd1;
    end else if (v > 11'd1024) begin
      return 11'd1024;
    end
    return v;
  endfunction

endpackage

[design/raycaster_sprite_projection_unit.sv]
// Channel | Direction | Handshake            | Contents
// in_     | input     | in_valid / in_ready  | action, positions, camera, frame, stripe, wall
// out_    | output    | out_valid / out_ready| bounds, depth, centre, texel column
// cfg     | input     | psel / penable       | screen and sheet registers
// A project word takes four divisions by the shared restoring divider, one quotient
// bit per cycle (82 + 82 + 32 + 32 bits), plus the multiply steps.
// A column word takes one 32-bit division.
// in_ready is high only while the sequencer is idle; a result waits in the output
// register, and a finished word stalls only while an older result is still untaken.
// Reset is synchronous and clears the held projection and loads the default registers.
`include "assert_macros.svh"

module raycaster_sprite_projection_unit
  import srp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_action,
  input  logic signed [31:0] in_sprite_x,
  input  logic signed [31:0] in_sprite_y,
  input  logic signed [31:0] in_player_x,
  input  logic signed [31:0] in_player_y,
  input  logic signed [31:0] in_dir_x,
  input  logic signed [31:0] in_dir_y,
  input  logic signed [31:0] in_plane_x,
  input  logic signed [31:0] in_plane_y,
  input  logic [2:0]         in_frame_index,
  input  logic [11:0]        in_stripe,
  input  logic [30:0]        in_wall_depth,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_visible,
  output logic [30:0]        out_depth,
  output logic signed [15:0] out_center_x,
  output logic [11:0]        out_start_x,
  output logic [11:0]        out_end_x,
  output logic [11:0]        out_start_y,
  output logic [11:0]        out_end_y,
  output logic               out_column_drawn,
  output logic [9:0]         out_tex_x,
  output logic [11:0]        out_source_x,
  output logic [9:0]         out_source_y
);

  localparam logic [4:0] ST_IDLE   = 5'd0;
  localparam logic [4:0] ST_M0     = 5'd1;
  localparam logic [4:0] ST_M1     = 5'd2;
  localparam logic [4:0] ST_M2     = 5'd3;
  localparam logic [4:0] ST_M3     = 5'd4;
  localparam logic [4:0] ST_M4     = 5'd5;
  localparam logic [4:0] ST_M5     = 5'd6;
  localparam logic [4:0] ST_M6     = 5'd7;
  localparam logic [4:0] ST_DEPTH  = 5'd8;
  localparam logic [4:0] ST_DEPTHW = 5'd9;
  localparam logic [4:0] ST_C0     = 5'd10;
  localparam logic [4:0] ST_C1     = 5'd11;
  localparam logic [4:0] ST_C2     = 5'd12;
  localparam logic [4:0] ST_CW     = 5'd13;
  localparam logic [4:0] ST_H0     = 5'd14;
  localparam logic [4:0] ST_H1     = 5'd15;
  localparam logic [4:0] ST_HW     = 5'd16;
  localparam logic [4:0] ST_W0     = 5'd17;
  localparam logic [4:0] ST_W1     = 5'd18;
  localparam logic [4:0] ST_WW     = 5'd19;
  localparam logic [4:0] ST_PFIN   = 5'd20;
  localparam logic [4:0] ST_K0     = 5'd21;
  localparam logic [4:0] ST_K1     = 5'd22;
  localparam logic [4:0] ST_KW     = 5'd23;
  localparam logic [4:0] ST_KFIN   = 5'd24;

  localparam logic [30:0] MAX31 = 31'h7FFFFFFF;

  logic [4:0] state_r, state_nxt;

  logic [12:0] scr_w_r, scr_h_r;
  logic [10:0] frm_w_r, frm_h_r;
  logic        two_row_r;
  logic [12:0] w_c, h_c;
  logic [10:0] fw_c, fh_c;

  logic                           act_r;
  logic signed [COORD_BITS:0]     sx_r, sy_r;
  logic signed [COORD_BITS-1:0]   dx_r, dy_r, plx_r, ply_r;
  logic [2:0]                     fi_r;
  logic [11:0]                    stripe_r;
  logic [30:0]                    wall_r;

  logic signed [PROD_W-1:0] t0_r, prod_r;
  logic signed [PD_W-1:0]   det_r, txn_r, tyn_r;
  logic [30:0]              ty_r;
  logic signed [15:0]       cx_r;
  logic [15:0]              hgt_r, wid_r;
  logic                     neg_r, zero_r;

  logic               held_vis_r;
  logic [30:0]        held_depth_r;
  logic signed [17:0] held_ts_r;
  logic [15:0]        held_w_r;
  logic [11:0]        held_sx_r, held_ex_r, held_ox_r;
  logic [9:0]         held_oy_r;

  logic               out_valid_r, out_free;

  logic signed [MUL_W-1:0] mul_a, mul_b;
  div_req_t                div_req;
  div_rsp_t                div_rsp;
  logic [DIV_NW-1:0]       div_num, div_quot;
  logic [DIV_DW-1:0]       div_den;

  logic signed [S_W-1:0]    s_c;
  logic signed [MUL_W-1:0]  s_lo, s_hi, w_op;
  logic signed [DIV_NW-1:0] cnum_c;
  logic [PD_W-1:0]          tyn_mag, det_mag;
  logic signed [DIV_DW-1:0] tyn2;
  logic [30:0]              ty_sat;
  logic                     d_reject;
  logic signed [15:0]       cx_sat;
  logic [15:0]              wid_sat;
  logic signed [18:0]       col_diff;

  logic signed [17:0] ts_c, te_c, yb_c, y0_c, y1_c;
  logic               vis_c;
  logic [11:0]        sx_c, ex_c, y0o_c, y1o_c;
  logic [13:0]        ox_full;
  logic [11:0]        ox_c;
  logic [9:0]         oy_c;
  logic               drawn_c;
  logic [10:0]        tex_c;
  logic [12:0]        src_full;

  assign w_c  = clamp_screen(scr_w_r);
  assign h_c  = clamp_screen(scr_h_r);
  assign fw_c = clamp_frame(frm_w_r);
  assign fh_c = clamp_frame(frm_h_r);

  assign pready = 1'b1;

  always_comb begin
    case (paddr[4:2])
      REG_SCREEN_W: prdata = 32'(scr_w_r);
      REG_SCREEN_H: prdata = 32'(scr_h_r);
      REG_FRAME_W:  prdata = 32'(frm_w_r);
      REG_FRAME_H:  prdata = 32'(frm_h_r);
      REG_TWO_ROW:  prdata = 32'(two_row_r);
      default:      prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scr_w_r   <= 13'd320;
      scr_h_r   <= 13'd240;
      frm_w_r   <= 11'd64;
      frm_h_r   <= 11'd64;
      two_row_r <= 1'b0;
    end else if (psel && penable && pwrite) begin
      case (paddr[4:2])
        REG_SCREEN_W: scr_w_r   <= pwdata[12:0];
        REG_SCREEN_H: scr_h_r   <= pwdata[12:0];
        REG_FRAME_W:  frm_w_r   <= pwdata[10:0];
        REG_FRAME_H:  frm_h_r   <= pwdata[10:0];
        REG_TWO_ROW:  two_row_r <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  srp_mul u_mul (
    .clk    (clk),
    .a      (mul_a),
    .b      (mul_b),
    .prod_r (prod_r)
  );

  srp_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .num   (div_num),
    .den   (div_den),
    .rsp   (div_rsp),
    .quot  (div_quot)
  );

  always_comb begin
    s_c     = S_W'(tyn_r) + S_W'(txn_r);
    s_lo    = signed'(MUL_W'(s_c[LO_W-1:0]));
    s_hi    = s_c[S_W-1:LO_W];
    w_op    = signed'(MUL_W'(w_c));
    cnum_c  = (DIV_NW'(prod_r) <<< LO_W) + DIV_NW'(t0_r);
    tyn_mag = tyn_r[PD_W-1] ? PD_W'(-tyn_r) : PD_W'(tyn_r);
    det_mag = det_r[PD_W-1] ? PD_W'(-det_r) : PD_W'(det_r);
    tyn2    = {tyn_r, 1'b0};
    ty_sat  = (div_quot > DIV_NW'(MAX31)) ? MAX31 : div_quot[30:0];
    d_reject = (tyn_r[PD_W-1] ^ det_r[PD_W-1]) || (ty_sat <= 31'(THRESH));
    if (neg_r) begin
      cx_sat = (div_quot > DIV_NW'(32768)) ? -16'sd32768 : -signed'(div_quot[15:0]);
    end else begin
      cx_sat = (div_quot > DIV_NW'(32767)) ? 16'sd32767 : signed'(div_quot[15:0]);
    end
    wid_sat  = (div_quot > DIV_NW'(65535)) ? 16'hFFFF : div_quot[15:0];
    col_diff = signed'(19'(stripe_r)) - 19'(held_ts_r);
  end

  always_comb begin
    mul_a         = '0;
    mul_b         = '0;
    div_req.start = 1'b0;
    div_req.iters = DIV_CW'(SMALL_N);
    div_num       = '0;
    div_den       = '0;
    case (state_r)
      ST_M0: begin
        mul_a = MUL_W'(plx_r);
        mul_b = MUL_W'(dy_r);
      end
      ST_M1: begin
        mul_a = MUL_W'(ply_r);
        mul_b = MUL_W'(dx_r);
      end
      ST_M2: begin
        mul_a = MUL_W'(dy_r);
        mul_b = MUL_W'(sx_r);
      end
      ST_M3: begin
        mul_a = MUL_W'(dx_r);
        mul_b = MUL_W'(sy_r);
      end
      ST_M4: begin
        mul_a = MUL_W'(plx_r);
        mul_b = MUL_W'(sy_r);
      end
      ST_M5: begin
        mul_a = MUL_W'(ply_r);
        mul_b = MUL_W'(sx_r);
      end
      ST_DEPTH: begin
        div_req.start = 1'b1;
        div_req.iters = DIV_CW'(DIV_NW);
        div_num       = {tyn_mag, FRAC_BITS'(0)};
        div_den       = DIV_DW'(det_mag);
      end
      ST_C0: begin
        mul_a = s_lo;
        mul_b = w_op;
      end
      ST_C1: begin
        mul_a = s_hi;
        mul_b = w_op;
      end
      ST_C2: begin
        div_req.start = 1'b1;
        div_req.iters = DIV_CW'(DIV_NW);
        div_num       = cnum_c[DIV_NW-1] ? DIV_NW'(-cnum_c) : DIV_NW'(cnum_c);
        div_den       = tyn2[DIV_DW-1] ? DIV_DW'(-tyn2) : DIV_DW'(tyn2);
      end
      ST_H0: begin
        mul_a = signed'(MUL_W'(h_c));
        mul_b = MUL_W'(SCALE);
      end
      ST_H1: begin
        div_req.start = 1'b1;
        div_num       = {prod_r[SMALL_N-1:0], (DIV_NW-SMALL_N)'(0)};
        div_den       = DIV_DW'(ty_r);
      end
      ST_W0: begin
        mul_a = signed'(MUL_W'(hgt_r));
        mul_b = signed'(MUL_W'(fw_c));
      end
      ST_W1: begin
        div_req.start = 1'b1;
        div_num       = {prod_r[SMALL_N-1:0], (DIV_NW-SMALL_N)'(0)};
        div_den       = DIV_DW'(fh_c);
      end
      ST_K0: begin
        mul_a = MUL_W'(col_diff);
        mul_b = signed'(MUL_W'(fw_c));
      end
      ST_K1: begin
        div_req.start = 1'b1;
        div_num       = {prod_r[SMALL_N-1:0], (DIV_NW-SMALL_N)'(0)};
        div_den       = DIV_DW'(held_w_r);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    ts_c    = 18'(cx_r) - signed'(18'(wid_r >> 1));
    te_c    = 18'(cx_r) + signed'(18'(wid_r >> 1));
    yb_c    = signed'(18'(h_c >> 1)) + signed'(18'(hgt_r >> 2));
    y0_c    = yb_c - signed'(18'(hgt_r >> 1));
    y1_c    = yb_c + signed'(18'(hgt_r >> 1));
    vis_c   = (ts_c < signed'(18'(w_c))) && !te_c[17];
    sx_c    = ts_c[17] ? 12'd0 : ts_c[11:0];
    ex_c    = (te_c > signed'(18'(w_c - 13'd1))) ? 12'(w_c - 13'd1) : te_c[11:0];
    y0o_c   = y0_c[17] ? 12'd0 : y0_c[11:0];
    y1o_c   = (y1_c >= signed'(18'(h_c))) ? 12'(h_c - 13'd1) : y1_c[11:0];
    ox_full = 14'(fi_r % FRAMES_PER_ROW) * 14'(fw_c);
    ox_c    = (ox_full > 14'd4095) ? 12'd4095 : ox_full[11:0];
    oy_c    = (two_row_r && (fi_r / FRAMES_PER_ROW) != 3'd0)
              ? ((fh_c > 11'd1023) ? 10'd1023 : fh_c[9:0]) : 10'd0;
    drawn_c = held_vis_r && (stripe_r >= held_sx_r) && (stripe_r < held_ex_r) &&
              (13'(stripe_r) < w_c) && (held_depth_r < wall_r);
    if (neg_r || held_w_r == 16'd0) begin
      tex_c = 11'd0;
    end else if (div_quot >= DIV_NW'(fw_c)) begin
      tex_c = fw_c - 11'd1;
    end else begin
      tex_c = div_quot[10:0];
    end
    src_full = 13'(held_ox_r) + 13'(tex_c);
  end

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (in_valid) state_nxt = in_action ? ST_K0 : ST_M0;
      ST_M0:     state_nxt = ST_M1;
      ST_M1:     state_nxt = ST_M2;
      ST_M2:     state_nxt = ST_M3;
      ST_M3:     state_nxt = ST_M4;
      ST_M4:     state_nxt = ST_M5;
      ST_M5:     state_nxt = ST_M6;
      ST_M6:     state_nxt = (det_r == '0) ? ST_PFIN : ST_DEPTH;
      ST_DEPTH:  state_nxt = ST_DEPTHW;
      ST_DEPTHW: if (div_rsp.done) state_nxt = d_reject ? ST_PFIN : ST_C0;
      ST_C0:     state_nxt = ST_C1;
      ST_C1:     state_nxt = ST_C2;
      ST_C2:     state_nxt = ST_CW;
      ST_CW:     if (div_rsp.done) state_nxt = ST_H0;
      ST_H0:     state_nxt = ST_H1;
      ST_H1:     state_nxt = ST_HW;
      ST_HW:     if (div_rsp.done) state_nxt = ST_W0;
      ST_W0:     state_nxt = ST_W1;
      ST_W1:     state_nxt = ST_WW;
      ST_WW:     if (div_rsp.done) state_nxt = ST_PFIN;
      ST_PFIN:   if (out_free) state_nxt = ST_IDLE;
      ST_K0:     state_nxt = ST_K1;
      ST_K1:     state_nxt = ST_KW;
      ST_KW:     if (div_rsp.done) state_nxt = ST_KFIN;
      ST_KFIN:   if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  assign in_ready = (state_r == ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_valid_r  <= 1'b0;
      held_vis_r   <= 1'b0;
      held_depth_r <= '0;
      held_ts_r    <= '0;
      held_w_r     <= '0;
      held_sx_r    <= '0;
      held_ex_r    <= '0;
      held_ox_r    <= '0;
      held_oy_r    <= '0;
    end else begin
      state_r <= state_nxt;
      if (((state_r == ST_PFIN) || (state_r == ST_KFIN)) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == ST_PFIN && out_free) begin
        if (zero_r) begin
          held_vis_r   <= 1'b0;
          held_depth_r <= '0;
          held_ts_r    <= '0;
          held_w_r     <= '0;
          held_sx_r    <= '0;
          held_ex_r    <= '0;
          held_ox_r    <= '0;
          held_oy_r    <= '0;
        end else begin
          held_vis_r   <= vis_c;
          held_depth_r <= ty_r;
          held_ts_r    <= ts_c;
          held_w_r     <= wid_r;
          held_sx_r    <= vis_c ? sx_c : 12'd0;
          held_ex_r    <= vis_c ? ex_c : 12'd0;
          held_ox_r    <= ox_c;
          held_oy_r    <= oy_c;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          act_r    <= in_action;
          sx_r     <= (COORD_BITS+1)'(in_sprite_x) - (COORD_BITS+1)'(in_player_x);
          sy_r     <= (COORD_BITS+1)'(in_sprite_y) - (COORD_BITS+1)'(in_player_y);
          dx_r     <= in_dir_x;
          dy_r     <= in_dir_y;
          plx_r    <= in_plane_x;
          ply_r    <= in_plane_y;
          fi_r     <= in_frame_index;
          stripe_r <= in_stripe;
          wall_r   <= in_wall_depth;
          zero_r   <= 1'b0;
        end
      end
      ST_M1: t0_r <= prod_r;
      ST_M2: det_r <= PD_W'(t0_r) - PD_W'(prod_r);
      ST_M3: t0_r <= prod_r;
      ST_M4: txn_r <= PD_W'(t0_r) - PD_W'(prod_r);
      ST_M5: t0_r <= prod_r;
      ST_M6: begin
        tyn_r  <= PD_W'(t0_r) - PD_W'(prod_r);
        zero_r <= (det_r == '0);
      end
      ST_DEPTHW: begin
        if (div_rsp.done) begin
          ty_r   <= ty_sat;
          zero_r <= d_reject;
        end
      end
      ST_C1: t0_r <= prod_r;
      ST_C2: neg_r <= cnum_c[DIV_NW-1] ^ tyn_r[PD_W-1];
      ST_CW: if (div_rsp.done) cx_r <= cx_sat;
      ST_HW: if (div_rsp.done) hgt_r <= div_quot[15:0];
      ST_WW: if (div_rsp.done) wid_r <= wid_sat;
      ST_K1: neg_r <= prod_r[PROD_W-1];
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_PFIN && out_free) begin
      out_column_drawn <= 1'b0;
      out_tex_x        <= '0;
      out_source_x     <= '0;
      out_source_y     <= '0;
      if (zero_r) begin
        out_visible  <= 1'b0;
        out_depth    <= '0;
        out_center_x <= '0;
        out_start_x  <= '0;
        out_end_x    <= '0;
        out_start_y  <= '0;
        out_end_y    <= '0;
      end else begin
        out_visible  <= vis_c;
        out_depth    <= ty_r;
        out_center_x <= cx_r;
        out_start_x  <= vis_c ? sx_c : 12'd0;
        out_end_x    <= vis_c ? ex_c : 12'd0;
        out_start_y  <= vis_c ? y0o_c : 12'd0;
        out_end_y    <= vis_c ? y1o_c : 12'd0;
      end
    end else if (state_r == ST_KFIN && out_free) begin
      out_visible      <= held_vis_r;
      out_depth        <= held_depth_r;
      out_center_x     <= 16'(held_ts_r + signed'(18'(held_w_r >> 1)));
      out_start_x      <= held_sx_r;
      out_end_x        <= held_ex_r;
      out_start_y      <= '0;
      out_end_y        <= '0;
      out_column_drawn <= drawn_c;
      out_tex_x        <= drawn_c ? tex_c[9:0] : 10'd0;
      out_source_x     <= drawn_c ? ((src_full > 13'd4095) ? 12'd4095 : src_full[11:0]) : 12'd0;
      out_source_y     <= drawn_c ? held_oy_r : 10'd0;
    end
  end

  assign out_valid = out_valid_r;

  `SRP_ASSERT(a_idle_div_quiet, (state_r == ST_IDLE) |-> !div_rsp.busy)
  `SRP_ASSERT_NEXT(a_one_word_at_a_time, in_valid && in_ready, !in_ready)
  `SRP_ASSERT(a_held_bounds_ordered, held_vis_r |-> (held_sx_r <= held_ex_r))

endmodule

[design/srp_mul.sv]
module srp_mul
  import srp_pkg::*;
(
  input  logic                     clk,
  input  logic signed [MUL_W-1:0]  a,
  input  logic signed [MUL_W-1:0]  b,
  output logic signed [PROD_W-1:0] prod_r
);

  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(a) * PROD_W'(b);
  end

endmodule

[design/srp_div.sv]
module srp_div
  import srp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  div_req_t          req,
  input  logic [DIV_NW-1:0] num,
  input  logic [DIV_DW-1:0] den,
  output div_rsp_t          rsp,
  output logic [DIV_NW-1:0] quot
);

  logic [DIV_NW-1:0] num_r, quot_r;
  logic [DIV_DW-1:0] den_r, rem_r, rem_nxt;
  logic [DIV_CW-1:0] cnt_r;
  logic              busy_r, done_r;
  logic [DIV_DW:0]   trial, diff;
  logic              ge;

  always_comb begin
    trial   = {rem_r, num_r[DIV_NW-1]};
    diff    = trial - {1'b0, den_r};
    ge      = trial >= {1'b0, den_r};
    rem_nxt = ge ? diff[DIV_DW-1:0] : trial[DIV_DW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= req.iters;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DIV_CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      num_r  <= num;
      den_r  <= den;
      rem_r  <= '0;
      quot_r <= '0;
    end else if (busy_r) begin
      num_r  <= num_r << 1;
      rem_r  <= rem_nxt;
      quot_r <= {quot_r[DIV_NW-2:0], ge};
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign quot     = quot_r;

endmodule
